/* hdl/psfc_pkg.sv */
// Package with shared constants and types for the PCM sample format converter.
`default_nettype none
package psfc_pkg;
   localparam int SampleWidth = 32;
   localparam int ModeWidth   = 3;

   typedef logic [SampleWidth-1:0] sample_type;
   typedef logic [ModeWidth-1:0]   mode_type;

   localparam mode_type MODE_I16_TO_F = 3'd0;
   localparam mode_type MODE_I24_TO_F = 3'd1;
   localparam mode_type MODE_I32_TO_F = 3'd2;
   localparam mode_type MODE_F_TO_I16 = 3'd3;
   localparam mode_type MODE_F_TO_I32 = 3'd4;

   // Gains as integers: 32767 and 2^31 - 1.
   localparam logic [30:0] GainI16 = 31'd32767;
   localparam logic [30:0] GainI32 = 31'h7FFF_FFFF;

   typedef struct packed {
      logic       last;
      mode_type   mode;
   } ctl_type;
endpackage
`default_nettype wire

/* hdl/psfc_stream_if.sv */
// Valid/ready stream interface carrying one sample and a last flag.
`default_nettype none
interface psfc_stream_if;
   logic        valid;
   logic        ready;
   logic [31:0] sample;
   logic        last;
   modport source (output valid, output sample, output last, input ready);
   modport sink (input valid, input sample, input last, output ready);
endinterface
`default_nettype wire

/* hdl/pcm_sample_format_converter.sv */
// Top level of the PCM sample format converter.
//
//   channel | direction | contents
//   req     | in        | sample (32), last (1), valid/ready
//   rsp     | out       | sample (32), last (1), valid/ready
//   csr     | in        | csr_write_enable, csr_write_data (3-bit mode)
//
// Transactions pass through the stages decode, normalize or multiply, round,
// and truncate and select; one transaction is accepted per cycle unless the
// output stalls. Reset is synchronous and clears the valid bits and the
// mode register to int16-to-float. The whole pipeline holds when the output
// stage is full and not taken, so a stall loses and repeats nothing.
`default_nettype none
module pcm_sample_format_converter (
   input  wire logic                 clock,
   input  wire logic                 reset,
   psfc_stream_if.sink               req,
   psfc_stream_if.source             rsp,
   input  wire logic                 csr_write_enable,
   input  wire psfc_pkg::mode_type   csr_write_data
);
   import psfc_pkg::*;

   mode_type mode_ff;
   logic     advance;
   ctl_type  in_ctl;
   ctl_type  out_ctl;

   always_ff @(posedge clock) begin
      if (reset) mode_ff <= MODE_I16_TO_F;
      else if (csr_write_enable) mode_ff <= csr_write_data;
   end

   // The pipeline moves when its last stage is empty or being taken.
   assign advance = !rsp.valid || rsp.ready;
   assign req.ready = advance;
   assign in_ctl = '{last: req.last, mode: mode_ff};

   psfc_pipe u_pipe (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req.valid),
      .in_sample  (req.sample),
      .in_ctl     (in_ctl),
      .out_valid  (rsp.valid),
      .out_sample (rsp.sample),
      .out_ctl    (out_ctl)
   );
   assign rsp.last = out_ctl.last;
endmodule
`default_nettype wire

/* hdl/psfc_pipe.sv */
// Four-stage conversion pipeline between integer PCM and single-precision float.
`default_nettype none
module psfc_pipe (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire logic                in_valid,
   input  wire psfc_pkg::sample_type in_sample,
   input  wire psfc_pkg::ctl_type   in_ctl,
   output logic                     out_valid,
   output psfc_pkg::sample_type     out_sample,
   output psfc_pkg::ctl_type        out_ctl
);
   import psfc_pkg::*;

   // Stage 1: decode. Integer paths produce sign/magnitude and an exponent bias;
   // float paths produce clamped mantissa, exponent and a zero flag.
   logic        v1_ff;
   ctl_type     c1_ff;
   logic        s1_sign_ff;
   logic [31:0] s1_mag_ff;      // integer magnitude (int to float)
   logic [7:0]  s1_bias_ff;     // exponent of bit 0 for int to float
   logic [23:0] s1_man_ff;      // float mantissa with hidden bit
   logic [7:0]  s1_exp_ff;      // float exponent (clamped)
   logic        s1_zero_ff;     // float result forced to zero (NaN or tiny)

   logic        s1_sign_in;
   logic [31:0] s1_mag_in;
   logic [7:0]  s1_bias_in;
   logic [23:0] s1_man_in;
   logic [7:0]  s1_exp_in;
   logic        s1_zero_in;
   logic [31:0] ival;

   always_comb begin
      ival = 32'd0;
      s1_bias_in = 8'd0;
      case (in_ctl.mode)
         MODE_I16_TO_F: begin
            ival = {{16{in_sample[15]}}, in_sample[15:0]};
            s1_bias_in = 8'd112; // 127 - 15
         end
         MODE_I24_TO_F: begin
            ival = {{8{in_sample[23]}}, in_sample[23:0]};
            s1_bias_in = 8'd104; // 127 - 23
         end
         MODE_I32_TO_F: begin
            ival = in_sample;
            s1_bias_in = 8'd96;  // 127 - 31
         end
         default: begin
            ival = 32'd0;
            s1_bias_in = 8'd0;
         end
      endcase
      s1_mag_in = ival[31] ? (~ival + 32'd1) : ival;
      // Float decode. Subnormals and zero truncate to zero; NaN gives zero.
      s1_sign_in = (in_ctl.mode == MODE_F_TO_I16 || in_ctl.mode == MODE_F_TO_I32)
                   ? in_sample[31] : ival[31];
      s1_zero_in = (in_sample[30:23] == 8'd0) ||
                   ((in_sample[30:23] == 8'hFF) && (in_sample[22:0] != 23'd0));
      if (in_sample[30:23] >= 8'd127) begin
         s1_man_in = 24'h800000;
         s1_exp_in = 8'd127;
      end else begin
         s1_man_in = {1'b1, in_sample[22:0]};
         s1_exp_in = in_sample[30:23];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (advance) v1_ff <= in_valid;
      if (advance) begin
         c1_ff <= in_ctl; s1_sign_ff <= s1_sign_in; s1_mag_ff <= s1_mag_in;
         s1_bias_ff <= s1_bias_in; s1_man_ff <= s1_man_in; s1_exp_ff <= s1_exp_in;
         s1_zero_ff <= s1_zero_in;
      end
   end

   // Stage 2: int path normalizes (leading-one count); float path multiplies.
   logic        v2_ff;
   ctl_type     c2_ff;
   logic        s2_sign_ff;
   logic [31:0] s2_norm_ff;
   logic [7:0]  s2_exp_ff;
   logic        s2_nz_ff;
   logic [54:0] s2_prod_ff;
   logic [7:0]  s2_fexp_ff;
   logic        s2_fzero_ff;

   logic [4:0]  lz;
   logic [31:0] norm_in;
   logic [30:0] gain;
   logic [54:0] prod_in;

   always_comb begin
      lz = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (s1_mag_ff[i]) lz = 5'(31 - i);
      end
      norm_in = s1_mag_ff << lz;
      // The int16 gain is placed 16 bits up so that both products have their
      // leading one at bit 53 or 54; the stage 3 exponent takes the 16 back.
      gain = (c1_ff.mode == MODE_F_TO_I32) ? GainI32 : {GainI16[14:0], 16'd0};
      prod_in = 55'(s1_man_ff) * 55'(gain);
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (advance) v2_ff <= v1_ff;
      if (advance) begin
         c2_ff <= c1_ff; s2_sign_ff <= s1_sign_ff; s2_norm_ff <= norm_in;
         s2_exp_ff <= s1_bias_ff + 8'(31 - 32'(lz));
         s2_nz_ff <= (s1_mag_ff != 32'd0);
         s2_prod_ff <= prod_in; s2_fexp_ff <= s1_exp_ff; s2_fzero_ff <= s1_zero_ff;
      end
   end

   // Stage 3: round to single precision (nearest even).
   // Int path: 32-bit normalized value to 24 bits. Float path: 55-bit product
   // normalized to a 24-bit mantissa, with exponent adjusted.
   logic        v3_ff;
   ctl_type     c3_ff;
   logic        s3_sign_ff;
   logic [31:0] s3_fbits_ff;
   logic [24:0] s3_pman_ff;   // rounded product mantissa, may carry
   logic [8:0]  s3_pexp_ff;   // weight exponent of mantissa LSB, biased offset
   logic        s3_fzero_ff;

   logic [24:0] ir;
   logic        ig, ist;
   logic [7:0]  iexp;
   logic        ptop;
   logic [23:0] pm;
   logic        pg, pst;
   logic [24:0] pr;

   always_comb begin
      ig  = s2_norm_ff[7];
      ist = |s2_norm_ff[6:0];
      ir  = {1'b0, s2_norm_ff[31:8]} + 25'(ig && (ist || s2_norm_ff[8]));
      iexp = s2_exp_ff + 8'(ir[24]);
      // Product man (2^23 scaled) * gain < 2^55 ; top bit 54 or 53.
      ptop = s2_prod_ff[54];
      if (ptop) begin
         pm = s2_prod_ff[54:31]; pg = s2_prod_ff[30]; pst = |s2_prod_ff[29:0];
      end else begin
         pm = s2_prod_ff[53:30]; pg = s2_prod_ff[29]; pst = |s2_prod_ff[28:0];
      end
      pr = {1'b0, pm} + 25'(pg && (pst || pm[0]));
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (advance) v3_ff <= v2_ff;
      if (advance) begin
         c3_ff <= c2_ff; s3_sign_ff <= s2_sign_ff;
         s3_fbits_ff <= s2_nz_ff
            ? {s2_sign_ff, iexp, (ir[24] ? 23'd0 : ir[22:0])} : 32'd0;
         s3_pman_ff <= pr;
         // The rounded mantissa's LSB weighs 2^(fexp - 120 + ptop), less 16 for
         // the int16 gain; the stored value is that exponent plus 136.
         s3_pexp_ff <= 9'(s2_fexp_ff) + 9'(ptop)
                       + ((c2_ff.mode == MODE_F_TO_I32) ? 9'd16 : 9'd0);
         s3_fzero_ff <= s2_fzero_ff;
      end
   end

   // Stage 4: truncate the rounded product toward zero, apply sign and limits, select by mode.
   logic        v4_ff;
   ctl_type     c4_ff;
   sample_type  s4_ff;
   logic [24:0] mn;
   logic [56:0] wide;
   logic [31:0] mag;
   logic [31:0] sres;
   sample_type  res;
   int          sh;

   always_comb begin
      // The integer value is pr * 2^(pexp - 136).
      mn = s3_pman_ff;
      sh = int'(s3_pexp_ff) - 136;
      if (sh >= 32) wide = {57{1'b1}};
      else if (sh >= 0) wide = 57'(mn) << sh[4:0];
      else if (sh > -32) wide = 57'(mn >> 6'(-sh));
      else wide = 57'd0;
      // A magnitude of 2^31 is kept for a negative value and saturates a positive one.
      if (wide >= 57'h8000_0000) mag = s3_sign_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
      else mag = wide[31:0];
      if (s3_fzero_ff) mag = 32'd0;
      sres = s3_sign_ff ? (~mag + 32'd1) : mag;
      case (c3_ff.mode)
         MODE_I16_TO_F, MODE_I24_TO_F, MODE_I32_TO_F: res = s3_fbits_ff;
         MODE_F_TO_I16: res = {16'd0, sres[15:0]};
         MODE_F_TO_I32: res = sres;
         default: res = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (advance) v4_ff <= v3_ff;
      if (advance) begin
         c4_ff <= c3_ff; s4_ff <= res;
      end
   end

   assign out_valid  = v4_ff;
   assign out_sample = s4_ff;
   assign out_ctl    = c4_ff;
endmodule
`default_nettype wire

/* hdl/psfc_checker.sv */
// Port-level checker for the PCM sample format converter, with its bind.
`default_nettype none
module psfc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_sample
);
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample))
      else $error("result changed under stall");
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready) else $error("input blocked while output empty");
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready ##1 rsp_ready [*3]
      |=> rsp_valid) else $error("transaction not delivered after four cycles");
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output valid after reset");
endmodule

bind pcm_sample_format_converter psfc_checker u_psfc_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_sample(rsp.sample));
`default_nettype wire
